/* sv/sapq_pkg.sv */
// ----------------------------------------------------------------------------
// sapq_pkg
// Shared types and codes for the sorted array priority queue: request kinds,
// result status codes, sequencer states and the compare unit's result.
// ----------------------------------------------------------------------------
package sapq_pkg;

    // Request kinds carried on the input tuser
    typedef enum logic [2:0] {
        REQ_PUSH  = 3'd0,
        REQ_POP   = 3'd1,
        REQ_TOP   = 3'd2,
        REQ_FIND  = 3'd3,
        REQ_READ  = 3'd4,
        REQ_CLEAR = 3'd5
    } req_t;

    // Result status carried on the output tuser
    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_EMPTY    = 3'd1,
        ST_FULL     = 3'd2,
        ST_RANGE    = 3'd3,
        ST_NOTFOUND = 3'd4
    } status_t;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN_ADDR,
        S_SCAN_CMP,
        S_SHIFT_ADDR,
        S_SHIFT_WR,
        S_PLACE,
        S_POP_ADDR,
        S_POP_WR,
        S_READ_WAIT,
        S_FINISH
    } state_t;

    // Compare unit result
    typedef struct packed {
        logic outranks;   // a stands strictly closer to the head than b
        logic equal;      // a equals b
    } cmp_res_t;

    localparam int VALUE_W  = 32;
    localparam int INDEX_W  = 5;
    localparam int COUNT_W  = 6;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 48;

endpackage

/* sv/sapq_cmp.sv */
// ----------------------------------------------------------------------------
// sapq_cmp
// Shared compare unit: ranks a new value against one stored entry under the
// current order and checks the two for equality.
// ----------------------------------------------------------------------------
module sapq_cmp
(
    input  logic                                 order_select,
    input  logic signed [sapq_pkg::VALUE_W-1:0]  a,
    input  logic signed [sapq_pkg::VALUE_W-1:0]  b,
    output sapq_pkg::cmp_res_t                   res
);

    // Rank: largest first when order_select is low, smallest first otherwise
    always_comb
    begin
        res.equal    = (a == b);
        res.outranks = order_select ? (a < b) : (a > b);
    end

endmodule

/* sv/sorted_array_priority_queue_unit.sv */
// ----------------------------------------------------------------------------
// sorted_array_priority_queue_unit
// Priority queue held as a sorted array of signed 32-bit values in one
// single-port-read / single-port-write memory, worked by a small sequencer
// around one shared compare unit.
// ----------------------------------------------------------------------------
//
//  channel    | direction | payload
//  -----------+-----------+-------------------------------------------------
//  s_t*       | in        | tuser: req_type; tdata: value, index
//  m_t*       | out       | tuser: status; tdata: data, found_index, count,
//             |           | is_empty
//  cfg_*      | in        | order_select, written when cfg_we is high
//
//  Top and read make one memory read, clear and refused requests none; push
//  scans from the head for its slot, shifts entries from the tail down to it
//  and writes the value; pop moves each later entry one slot toward the head;
//  find scans to a hit or the tail. With one read port and one compare unit,
//  each entry visited takes a memory read and then a compare or a write.
//  Reset clears the count, the order bit and all handshake state; the entry
//  memory is not cleared. s_tready is high only while the sequencer is idle;
//  a finished result waits in the output register while m_tready is low.
// ----------------------------------------------------------------------------
module sorted_array_priority_queue_unit
#(
    parameter int CAPACITY = 32
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [sapq_pkg::IN_DATA_W-1:0]  s_tdata,   // [31:0] value, [36:32] index,
                                                       // [39:37] zero
    input  logic [2:0]  s_tuser,   // [2:0] req_type

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [sapq_pkg::OUT_DATA_W-1:0] m_tdata,   // [31:0] data, [36:32] found_index,
                                                       // [42:37] count, [43] is_empty,
                                                       // [47:44] zero
    output logic [2:0]  m_tuser,   // [2:0] status

    input  logic        cfg_we,
    input  logic        cfg_wdata
);

    localparam int AW = $clog2(CAPACITY);
    localparam int IW = $clog2(CAPACITY + 1);
    localparam int XW = (IW > sapq_pkg::INDEX_W) ? IW : sapq_pkg::INDEX_W;
    localparam logic [IW-1:0] CAP_C = IW'(CAPACITY);
    localparam logic [IW-1:0] ONE_C = IW'(1);

    // Sequencer and request registers
    sapq_pkg::state_t                        state_reg, state_next;
    sapq_pkg::req_t                          req_reg, req_next;
    logic signed [sapq_pkg::VALUE_W-1:0]     val_reg, val_next;
    logic [IW-1:0]                           i_reg, i_next;
    logic [IW-1:0]                           pos_reg, pos_next;
    logic [IW-1:0]                           count_reg, count_next;
    logic                                    order_reg;

    // Result being built
    sapq_pkg::status_t                       res_status_reg, res_status_next;
    logic signed [sapq_pkg::VALUE_W-1:0]     res_data_reg, res_data_next;
    logic [sapq_pkg::INDEX_W-1:0]            res_fidx_reg, res_fidx_next;

    // Output register
    logic                                    m_tvalid_reg, m_tvalid_next;
    sapq_pkg::status_t                       out_status_reg;
    logic signed [sapq_pkg::VALUE_W-1:0]     out_data_reg;
    logic [sapq_pkg::INDEX_W-1:0]            out_fidx_reg;
    logic [sapq_pkg::COUNT_W-1:0]            out_count_reg;
    logic                                    out_empty_reg;

    // Entry memory
    logic signed [sapq_pkg::VALUE_W-1:0]     mem [CAPACITY];
    logic signed [sapq_pkg::VALUE_W-1:0]     rd_data_reg;
    logic [AW-1:0]                           mem_raddr;
    logic [AW-1:0]                           mem_waddr;
    logic signed [sapq_pkg::VALUE_W-1:0]     mem_wdata;
    logic                                    mem_we;

    // Input fields
    sapq_pkg::req_t                          in_req;
    logic signed [sapq_pkg::VALUE_W-1:0]     in_value;
    logic [sapq_pkg::INDEX_W-1:0]            in_index;

    // Conditions
    logic                                    accept;
    logic                                    out_free;
    logic                                    cnt_zero;
    logic                                    cnt_full;
    logic                                    idx_bad;
    logic                                    i_at_count;
    logic                                    i_last;
    logic                                    i_at_pos;
    logic                                    hit;
    sapq_pkg::cmp_res_t                      cmp_res;

    assign in_req   = sapq_pkg::req_t'(s_tuser);
    assign in_value = s_tdata[31:0];
    assign in_index = s_tdata[36:32];

    assign s_tready   = (state_reg == sapq_pkg::S_IDLE);
    assign accept     = s_tvalid && s_tready;
    assign out_free   = !m_tvalid_reg || m_tready;
    assign cnt_zero   = (count_reg == '0);
    assign cnt_full   = (count_reg == CAP_C);
    assign idx_bad    = (XW'(in_index) >= XW'(count_reg));
    assign i_at_count = (i_reg == count_reg);
    assign i_last     = ((i_reg + ONE_C) == count_reg);
    assign i_at_pos   = (i_reg == pos_reg);

    // Shared compare unit: new value against the entry just read
    sapq_cmp u_cmp
    (
        .order_select (order_reg),
        .a            (val_reg),
        .b            (rd_data_reg),
        .res          (cmp_res)
    );

    assign hit = (req_reg == sapq_pkg::REQ_PUSH) ? cmp_res.outranks : cmp_res.equal;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sapq_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    case (in_req)
                        sapq_pkg::REQ_PUSH:
                            state_next = cnt_full ? sapq_pkg::S_FINISH : sapq_pkg::S_SCAN_ADDR;
                        sapq_pkg::REQ_POP:
                            state_next = cnt_zero ? sapq_pkg::S_FINISH : sapq_pkg::S_POP_ADDR;
                        sapq_pkg::REQ_TOP:
                            state_next = cnt_zero ? sapq_pkg::S_FINISH : sapq_pkg::S_READ_WAIT;
                        sapq_pkg::REQ_FIND:
                            state_next = sapq_pkg::S_SCAN_ADDR;
                        sapq_pkg::REQ_READ:
                            state_next = idx_bad ? sapq_pkg::S_FINISH : sapq_pkg::S_READ_WAIT;
                        default:
                            state_next = sapq_pkg::S_FINISH;
                    endcase
                end
            end
            sapq_pkg::S_SCAN_ADDR:
            begin
                if (!i_at_count)
                    state_next = sapq_pkg::S_SCAN_CMP;
                else if (req_reg == sapq_pkg::REQ_PUSH)
                    state_next = sapq_pkg::S_SHIFT_ADDR;
                else
                    state_next = sapq_pkg::S_FINISH;
            end
            sapq_pkg::S_SCAN_CMP:
            begin
                if (!hit)
                    state_next = sapq_pkg::S_SCAN_ADDR;
                else if (req_reg == sapq_pkg::REQ_PUSH)
                    state_next = sapq_pkg::S_SHIFT_ADDR;
                else
                    state_next = sapq_pkg::S_FINISH;
            end
            sapq_pkg::S_SHIFT_ADDR:
                state_next = i_at_pos ? sapq_pkg::S_PLACE : sapq_pkg::S_SHIFT_WR;
            sapq_pkg::S_SHIFT_WR:
                state_next = sapq_pkg::S_SHIFT_ADDR;
            sapq_pkg::S_PLACE:
                state_next = sapq_pkg::S_FINISH;
            sapq_pkg::S_POP_ADDR:
                state_next = i_last ? sapq_pkg::S_FINISH : sapq_pkg::S_POP_WR;
            sapq_pkg::S_POP_WR:
                state_next = sapq_pkg::S_POP_ADDR;
            sapq_pkg::S_READ_WAIT:
                state_next = sapq_pkg::S_FINISH;
            sapq_pkg::S_FINISH:
                state_next = out_free ? sapq_pkg::S_IDLE : sapq_pkg::S_FINISH;
            default:
                state_next = sapq_pkg::S_IDLE;
        endcase
    end

    // Datapath controls and register updates
    always_comb
    begin
        req_next        = req_reg;
        val_next        = val_reg;
        i_next          = i_reg;
        pos_next        = pos_reg;
        count_next      = count_reg;
        res_status_next = res_status_reg;
        res_data_next   = res_data_reg;
        res_fidx_next   = res_fidx_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        mem_raddr       = AW'(i_reg);
        mem_waddr       = AW'(i_reg);
        mem_wdata       = rd_data_reg;
        mem_we          = 1'b0;
        unique case (state_reg)
            sapq_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    req_next        = in_req;
                    val_next        = in_value;
                    i_next          = '0;
                    res_status_next = sapq_pkg::ST_OK;
                    res_data_next   = '0;
                    res_fidx_next   = '0;
                    case (in_req)
                        sapq_pkg::REQ_PUSH:
                            if (cnt_full)
                                res_status_next = sapq_pkg::ST_FULL;
                        sapq_pkg::REQ_POP:
                            if (cnt_zero)
                                res_status_next = sapq_pkg::ST_EMPTY;
                        sapq_pkg::REQ_TOP:
                        begin
                            mem_raddr = '0;
                            if (cnt_zero)
                                res_status_next = sapq_pkg::ST_EMPTY;
                        end
                        sapq_pkg::REQ_READ:
                        begin
                            mem_raddr = AW'(XW'(in_index));
                            if (idx_bad)
                                res_status_next = sapq_pkg::ST_RANGE;
                        end
                        sapq_pkg::REQ_CLEAR:
                            count_next = '0;
                        default:
                        begin
                        end
                    endcase
                end
            end
            sapq_pkg::S_SCAN_ADDR:
            begin
                // Read entry i, or finish the scan at the tail
                if (i_at_count)
                begin
                    if (req_reg == sapq_pkg::REQ_PUSH)
                        pos_next = count_reg;
                    else
                        res_status_next = sapq_pkg::ST_NOTFOUND;
                end
            end
            sapq_pkg::S_SCAN_CMP:
            begin
                if (!hit)
                    i_next = i_reg + ONE_C;
                else if (req_reg == sapq_pkg::REQ_PUSH)
                begin
                    // Insert here: shift from the tail down to this slot
                    pos_next = i_reg;
                    i_next   = count_reg;
                end
                else
                    res_fidx_next = sapq_pkg::INDEX_W'(i_reg);
            end
            sapq_pkg::S_SHIFT_ADDR:
                mem_raddr = AW'(i_reg - ONE_C);
            sapq_pkg::S_SHIFT_WR:
            begin
                mem_we    = 1'b1;
                mem_waddr = AW'(i_reg);
                i_next    = i_reg - ONE_C;
            end
            sapq_pkg::S_PLACE:
            begin
                mem_we     = 1'b1;
                mem_waddr  = AW'(pos_reg);
                mem_wdata  = val_reg;
                count_next = count_reg + ONE_C;
            end
            sapq_pkg::S_POP_ADDR:
            begin
                mem_raddr = AW'(i_reg + ONE_C);
                if (i_last)
                    count_next = count_reg - ONE_C;
            end
            sapq_pkg::S_POP_WR:
            begin
                mem_we    = 1'b1;
                mem_waddr = AW'(i_reg);
                i_next    = i_reg + ONE_C;
            end
            sapq_pkg::S_READ_WAIT:
                res_data_next = rd_data_reg;
            sapq_pkg::S_FINISH:
            begin
                if (out_free)
                    m_tvalid_next = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= sapq_pkg::S_IDLE;
            count_reg    <= '0;
            order_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_we)
                order_reg <= cfg_wdata;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        req_reg        <= req_next;
        val_reg        <= val_next;
        i_reg          <= i_next;
        pos_reg        <= pos_next;
        res_status_reg <= res_status_next;
        res_data_reg   <= res_data_next;
        res_fidx_reg   <= res_fidx_next;
        if (state_reg == sapq_pkg::S_FINISH && out_free)
        begin
            out_status_reg <= res_status_reg;
            out_data_reg   <= res_data_reg;
            out_fidx_reg   <= res_fidx_reg;
            out_count_reg  <= sapq_pkg::COUNT_W'(count_reg);
            out_empty_reg  <= cnt_zero;
        end
    end

    // Entry memory: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        rd_data_reg <= mem[mem_raddr];
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {4'b0000, out_empty_reg, out_count_reg, out_fidx_reg, out_data_reg};

`ifndef SYNTHESIS
    // Count never passes capacity
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP_C)
        else $error("entry count above capacity");

    // Count moves by one, or drops to zero on clear
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |->
            (count_reg == $past(count_reg) + ONE_C ||
             count_reg == $past(count_reg) - ONE_C ||
             count_reg == '0))
        else $error("entry count jumped");

    // Memory writes only from the write states, inside the array
    a_write_state: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> ((state_reg == sapq_pkg::S_SHIFT_WR ||
                     state_reg == sapq_pkg::S_PLACE ||
                     state_reg == sapq_pkg::S_POP_WR) &&
                    (IW'(mem_waddr) < CAP_C)))
        else $error("stray memory write");

    // A finished result reaches the output register
    a_result_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sapq_pkg::S_FINISH && out_free) |=> m_tvalid)
        else $error("result lost");
`endif

endmodule
